>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define POFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The same check, sampled only when an enabling condition holds.
`define POFR_ASSERT_WHEN(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

>>> rtl/pofr_pkg.sv
`default_nettype none

package pofr_pkg;

   localparam int ByteW      = 8;
   localparam int PinW       = 4;
   localparam int CountW     = 18;
   localparam int MsPerSecond = 1000;
   localparam int ReqDataW   = 24;
   localparam int RspDataW   = 24;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TICK  = 2'd0;
   localparam kind_type KIND_FAULT = 2'd1;
   localparam kind_type KIND_SET   = 2'd2;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_RETRY_SECONDS = 2'd0;
   localparam reg_index_type REG_FORCED_RETRY  = 2'd1;
   localparam reg_index_type REG_ON_POLARITY   = 2'd2;
   localparam reg_index_type REG_FAULT_POLARITY = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] retry_seconds;
      logic             forced_retry;
      logic [PinW-1:0]  on_polarity_mask;
      logic             fault_polarity;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic             fault_level;
      logic             fault_level_after;
      logic [ByteW-1:0] channel;
      logic [ByteW-1:0] target_value;
   } item_type;

   typedef struct packed {
      logic [PinW-1:0]  pin_levels;
      logic             report_valid;
      logic             healthy;
      logic             ack_valid;
      logic [ByteW-1:0] ack_channel;
      logic [ByteW-1:0] ack_value;
   } result_type;

   // Level of one channel pin after a drive; targets other than off and on keep the pin.
   function automatic logic drive_level(input logic [ByteW-1:0] target, input logic fault,
                                        input logic ignore_fault, input logic on_level,
                                        input logic current);
      logic lvl;
      lvl = current;
      if (target == ByteW'(0)) begin
         lvl = ~on_level;
      end else if (target == ByteW'(1)) begin
         lvl = (!fault || ignore_fault) ? on_level : ~on_level;
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

>>> rtl/protected_output_fault_retry_unit.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   req_tuser kind, req_tdata fault levels, command
// rsp       out        rsp_tvalid/rsp_tready   rsp_tuser flags, rsp_tdata pins, health, echo
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// Each request is held in the input register while it is evaluated against the channel state;
// the response is registered and offered, and a request is taken every cycle unless it stalls.
// Reset is synchronous and active high; it clears the state and resets the configuration at once.
// A stalled response holds the pipeline; the input register still accepts while the
// output register is being drained in the same cycle.

`include "assert_macros.svh"

module protected_output_fault_retry_unit #(
   parameter int CHANNELS = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [0] fault_level, [1] fault_level_after, [9:2] channel, [17:10] target_value
   input  wire logic [pofr_pkg::ReqDataW-1:0]   req_tdata,
   // [1:0] kind
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [3:0] pin_levels, [4] healthy, [12:5] ack_channel, [20:13] ack_value
   output logic [pofr_pkg::RspDataW-1:0]        rsp_tdata,
   // [0] report_valid, [1] ack_valid
   output logic [1:0]                           rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [7:0]                      csr_data
);
   import pofr_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       step;

   assign csr_ready = 1'b1;

   pofr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.kind              = req_tuser;
      item_in.fault_level       = req_tdata[0];
      item_in.fault_level_after = req_tdata[1];
      item_in.channel           = req_tdata[9:2];
      item_in.target_value      = req_tdata[17:10];
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   pofr_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.ack_value, rsp_ff.ack_channel, rsp_ff.healthy,
                        rsp_ff.pin_levels};
   assign rsp_tuser  = {rsp_ff.ack_valid, rsp_ff.report_valid};

   `POFR_ASSERT_WHEN(unused_pins_low, clock, reset, out_valid_ff, (rsp_ff.pin_levels >> CHANNELS) == '0, "pin driven on a channel that does not exist")
   `POFR_ASSERT_WHEN(healthy_needs_report, clock, reset, out_valid_ff, !rsp_ff.healthy || rsp_ff.report_valid, "health flag without a report")
   `POFR_ASSERT_WHEN(report_ack_exclusive, clock, reset, out_valid_ff, !(rsp_ff.report_valid && rsp_ff.ack_valid), "report and acknowledgement in one response")

endmodule

`default_nettype wire

>>> rtl/pofr_csr.sv
`default_nettype none

module pofr_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire pofr_pkg::reg_index_type csr_index,
   input  wire logic [7:0]             csr_data,
   output pofr_pkg::cfg_type           cfg
);
   import pofr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RETRY_SECONDS:  cfg_in.retry_seconds    = csr_data;
            REG_FORCED_RETRY:   cfg_in.forced_retry     = csr_data[0];
            REG_ON_POLARITY:    cfg_in.on_polarity_mask = csr_data[PinW-1:0];
            REG_FAULT_POLARITY: cfg_in.fault_polarity   = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_seconds    <= '0;
         cfg_ff.forced_retry     <= 1'b0;
         cfg_ff.on_polarity_mask <= '1;
         cfg_ff.fault_polarity   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/pofr_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module pofr_ctrl #(
   parameter int CHANNELS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire pofr_pkg::item_type item,
   input  wire pofr_pkg::cfg_type  cfg,
   output pofr_pkg::result_type    result
);
   import pofr_pkg::*;

   localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [ByteW-1:0]    target_ff [CHANNELS];
   logic [ByteW-1:0]    target_in [CHANNELS];
   logic [ByteW-1:0]    target_set [CHANNELS];
   logic [ByteW-1:0]    drive_target [CHANNELS];
   logic                fault_ff, fault_in;
   logic                retry_active_ff, retry_active_in;
   logic [CountW-1:0]   countdown_ff, countdown_in;
   logic [CHANNELS-1:0] pins_ff, pins_in;
   logic [CHANNELS-1:0] driven;

   logic              sample_now;
   logic              sample_after;
   logic              set_hit;
   logic [IdxW-1:0]   set_idx;
   logic              ignore_fault;
   logic [CountW-1:0] reload;
   logic              report;
   logic              ack;

   assign sample_now   = (item.fault_level == cfg.fault_polarity);
   assign sample_after = (item.fault_level_after == cfg.fault_polarity);
   assign set_hit      = (item.channel < ByteW'(CHANNELS));
   assign set_idx      = item.channel[IdxW-1:0];
   assign ignore_fault = cfg.forced_retry && (item.kind != KIND_FAULT);
   assign reload       = CountW'(CountW'(cfg.retry_seconds) * CountW'(MsPerSecond));

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         target_set[ch] = (set_hit && set_idx == IdxW'(ch)) ? item.target_value : target_ff[ch];
         drive_target[ch] = (item.kind == KIND_SET) ? target_set[ch] : target_ff[ch];
         driven[ch] = drive_level(drive_target[ch], sample_now, ignore_fault,
                                  cfg.on_polarity_mask[ch], pins_ff[ch]);
      end
   end

   always_comb begin
      target_in       = target_ff;
      fault_in        = fault_ff;
      retry_active_in = retry_active_ff;
      countdown_in    = countdown_ff;
      pins_in         = pins_ff;
      report          = 1'b0;
      ack             = 1'b0;
      case (item.kind)
         KIND_TICK: begin
            if (retry_active_ff) begin
               if (countdown_ff <= CountW'(1)) begin
                  pins_in  = driven;
                  fault_in = cfg.forced_retry ? sample_after : sample_now;
                  if (fault_in) begin
                     retry_active_in = 1'b1;
                     countdown_in    = reload;
                  end else begin
                     retry_active_in = 1'b0;
                     countdown_in    = '0;
                     report          = 1'b1;
                  end
               end else begin
                  countdown_in = countdown_ff - CountW'(1);
               end
            end
         end
         KIND_FAULT: begin
            fault_in = sample_now;
            pins_in  = driven;
            if (sample_now) begin
               if (cfg.retry_seconds != '0) begin
                  retry_active_in = 1'b1;
                  countdown_in    = reload;
               end else begin
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     target_in[ch] = '0;
                  end
               end
            end
            report = 1'b1;
         end
         KIND_SET: begin
            if (set_hit) begin
               target_in = target_set;
               fault_in  = sample_now;
               pins_in   = driven;
            end
            ack = 1'b1;
         end
         default: begin
            pins_in = pins_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            target_ff[ch] <= '0;
         end
         fault_ff        <= 1'b0;
         retry_active_ff <= 1'b0;
         countdown_ff    <= '0;
         pins_ff         <= '0;
      end else if (step) begin
         target_ff       <= target_in;
         fault_ff        <= fault_in;
         retry_active_ff <= retry_active_in;
         countdown_ff    <= countdown_in;
         pins_ff         <= pins_in;
      end
   end

   always_comb begin
      result.pin_levels   = PinW'(pins_in);
      result.report_valid = report;
      result.healthy      = report && !fault_in;
      result.ack_valid    = ack;
      result.ack_channel  = ack ? item.channel : '0;
      result.ack_value    = ack ? item.target_value : '0;
   end

   `POFR_ASSERT(idle_countdown_zero, clock, reset, !retry_active_ff |-> countdown_ff == '0, "countdown left running while retry is idle")
   `POFR_ASSERT_WHEN(fault_clears_targets, clock, reset, step && item.kind == KIND_FAULT && sample_now && cfg.retry_seconds == '0, ##1 target_ff[0] == '0, "targets not cleared on fault without retry")

endmodule

`default_nettype wire
